FILE: hdl/ssh_pkg.sv
`default_nettype none

package ssh_pkg;

    // sizing of the filter
    localparam int NUM_PATTERNS      = 4;
    localparam int MAX_PATTERN_BYTES = 8;
    localparam int REG_SLOTS         = 4;
    localparam int PAT_W             = 64;
    localparam int LEN_W             = 4;
    localparam int SLOT_W            = 2;
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 64;
    localparam int HC_W              = $clog2(MAX_PATTERN_BYTES);
    localparam int CNT_W             = $clog2(MAX_PATTERN_BYTES + 1);

    // input command codes
    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_ZERO  = 3'd0,
        CFG_PATTERN_ONE   = 3'd1,
        CFG_PATTERN_TWO   = 3'd2,
        CFG_PATTERN_THREE = 3'd3,
        CFG_LENGTHS       = 3'd4
    } ssh_cfg_idx_t;

    typedef logic [MAX_PATTERN_BYTES-1:0][7:0] ssh_buf_t;

    // stop string configuration
    typedef struct packed {
        logic [REG_SLOTS-1:0][PAT_W-1:0] pat;
        logic [LEN_W*REG_SLOTS-1:0]      lens;
    } ssh_cfg_t;

    // filter state
    typedef struct packed {
        ssh_buf_t          held;
        logic [HC_W-1:0]   hc;
        logic              seen;
        logic [SLOT_W-1:0] slot;
    } ssh_state_t;

    // outcome of one transaction
    typedef struct packed {
        ssh_buf_t         rel_bytes;
        logic [CNT_W-1:0] rel_cnt;
        ssh_state_t       next;
    } ssh_step_t;

endpackage

`default_nettype wire

FILE: hdl/ssh_step.sv
`default_nettype none

module ssh_step (
    input  wire ssh_pkg::ssh_cfg_t   cfg,
    input  wire ssh_pkg::ssh_state_t st,
    input  wire logic                cmd,
    input  wire logic [7:0]          din,
    output ssh_pkg::ssh_step_t       res
);

    localparam int MAXB = ssh_pkg::MAX_PATTERN_BYTES;
    localparam int NS   = ssh_pkg::REG_SLOTS;

    logic [ssh_pkg::LEN_W-1:0]  len_eff [NS];
    ssh_pkg::ssh_buf_t          bufv;
    logic [ssh_pkg::CNT_W-1:0]  n;
    logic [NS-1:0]              mt [MAXB];
    logic [MAXB-1:0]            pre;
    logic [MAXB-1:0]            end_any;
    logic                       found;
    logic [ssh_pkg::CNT_W-1:0]  best_e;
    logic [ssh_pkg::HC_W-1:0]   best_i;
    logic [ssh_pkg::SLOT_W-1:0] best_s;
    logic [ssh_pkg::CNT_W-1:0]  rel_nm;
    ssh_pkg::ssh_buf_t          held_nm;

    // effective slot lengths, zero for an unused slot or one longer than MAX_PATTERN_BYTES
    always_comb begin
        logic [ssh_pkg::LEN_W-1:0] l;
        for (int s = 0; s < NS; s++) begin
            l = cfg.lens[ssh_pkg::LEN_W*s +: ssh_pkg::LEN_W];
            if (s < ssh_pkg::NUM_PATTERNS && l != '0 && int'(l) <= MAXB) begin
                len_eff[s] = l;
            end else begin
                len_eff[s] = '0;
            end
        end
    end

    // held bytes followed by the new byte
    always_comb begin
        for (int p = 0; p < MAXB; p++) begin
            bufv[p] = (ssh_pkg::HC_W'(p) < st.hc) ? st.held[p] : din;
        end
        n = ssh_pkg::CNT_W'(st.hc) + ssh_pkg::CNT_W'(1);
    end

    // full matches by start and slot, prefix matches of each suffix
    always_comb begin
        logic ok;
        logic any;
        for (int i = 0; i < MAXB; i++) begin
            any = 1'b0;
            for (int s = 0; s < NS; s++) begin
                ok = (len_eff[s] != '0) && ((i + int'(len_eff[s])) <= int'(n));
                for (int j = 0; j < MAXB - i; j++) begin
                    if (j < int'(len_eff[s]) && bufv[i+j] != cfg.pat[s][8*j +: 8]) begin
                        ok = 1'b0;
                    end
                end
                mt[i][s] = ok;

                ok = (len_eff[s] != '0) && (i < int'(n)) &&
                     ((i + int'(len_eff[s])) > int'(n));
                for (int j = 0; j < MAXB - i; j++) begin
                    if ((i + j) < int'(n) && bufv[i+j] != cfg.pat[s][8*j +: 8]) begin
                        ok = 1'b0;
                    end
                end
                any = any | ok;
            end
            pre[i] = any;
        end
    end

    // earliest end, then earliest start, then lowest slot
    always_comb begin
        end_any = '0;
        for (int e = 1; e <= MAXB; e++) begin
            for (int i = 0; i < MAXB; i++) begin
                for (int s = 0; s < NS; s++) begin
                    if (mt[i][s] && (i + int'(len_eff[s])) == e) begin
                        end_any[e-1] = 1'b1;
                    end
                end
            end
        end
        found  = |end_any;
        best_e = '0;
        for (int e = MAXB; e >= 1; e--) begin
            if (end_any[e-1]) begin
                best_e = ssh_pkg::CNT_W'(e);
            end
        end
        best_i = '0;
        best_s = '0;
        for (int i = MAXB - 1; i >= 0; i--) begin
            for (int s = NS - 1; s >= 0; s--) begin
                if (mt[i][s] && (i + int'(len_eff[s])) == int'(best_e)) begin
                    best_i = ssh_pkg::HC_W'(i);
                    best_s = ssh_pkg::SLOT_W'(s);
                end
            end
        end
    end

    // no match: keep the longest suffix that starts some stop string
    always_comb begin
        logic [ssh_pkg::HC_W-1:0] idx;
        rel_nm = n;
        for (int i = MAXB - 1; i >= 0; i--) begin
            if (pre[i]) begin
                rel_nm = ssh_pkg::CNT_W'(i);
            end
        end
        for (int p = 0; p < MAXB; p++) begin
            idx        = rel_nm[ssh_pkg::HC_W-1:0] + ssh_pkg::HC_W'(p);
            held_nm[p] = bufv[idx];
        end
    end

    // next state and released bytes
    always_comb begin
        res.rel_bytes = bufv;
        res.next      = st;
        if (cmd == ssh_pkg::CMD_FLUSH) begin
            res.rel_cnt = st.seen ? '0 : ssh_pkg::CNT_W'(st.hc);
            res.next.hc = '0;
        end else if (st.seen) begin
            res.rel_cnt = '0;
        end else if (found) begin
            res.rel_cnt   = ssh_pkg::CNT_W'(best_i);
            res.next.hc   = '0;
            res.next.seen = 1'b1;
            res.next.slot = best_s;
        end else begin
            res.rel_cnt   = rel_nm;
            res.next.hc   = ssh_pkg::HC_W'(n - rel_nm);
            res.next.held = held_nm;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/stop_string_holdback_filter.sv
// An accepted input transaction is registered in the input register and then moves into
//   the result batch register, which offers its results; a busy batch register holds it back.
// Throughput: one input per cycle while each input gives one result and m_tready is high;
//   an input that releases k bytes gives max(1, k) results, one per output handshake,
//   so the drain of the result batch sets the rate.
// Reset: aresetn low clears the pipeline, the match status, held count, the pattern and
//   length registers; held byte storage is not cleared.
`default_nettype none

module stop_string_holdback_filter (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_we,
    input  wire logic [ssh_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [ssh_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [7:0]                         s_tdata,  // data_byte
    input  wire logic                               s_tuser,  // command
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [15:0]                             m_tdata,  // out_byte, stopped, stop_index
    output logic                                    m_tuser,  // out_valid
    output logic                                    m_tlast
);

    localparam int NS = ssh_pkg::REG_SLOTS;

    // configuration registers
    logic [NS-1:0][ssh_pkg::PAT_W-1:0]    pat_reg;
    logic [ssh_pkg::LEN_W*NS-1:0]         lens_reg;

    // input register
    logic                                 in_vld_reg;
    logic                                 in_cmd_reg;
    logic [7:0]                           in_byte_reg;

    // filter state
    ssh_pkg::ssh_buf_t                    held_reg;
    logic [ssh_pkg::HC_W-1:0]             hc_reg;
    logic                                 seen_reg;
    logic [ssh_pkg::SLOT_W-1:0]           slot_reg;

    // result batch register
    logic                                 bat_vld_reg;
    ssh_pkg::ssh_buf_t                    bat_buf_reg;
    logic                                 bat_any_reg;
    logic [ssh_pkg::HC_W-1:0]             bat_idx_reg;
    logic [ssh_pkg::HC_W-1:0]             bat_lastidx_reg;
    logic                                 bat_stop_reg;
    logic [ssh_pkg::SLOT_W-1:0]           bat_slot_reg;

    ssh_pkg::ssh_cfg_t                    cfg;
    ssh_pkg::ssh_state_t                  st;
    ssh_pkg::ssh_step_t                   res;
    logic                                 s_fire;
    logic                                 m_fire;
    logic                                 bat_done;
    logic                                 load;
    logic [7:0]                           out_byte;

    assign cfg.pat  = pat_reg;
    assign cfg.lens = lens_reg;
    assign st.held  = held_reg;
    assign st.hc    = hc_reg;
    assign st.seen  = seen_reg;
    assign st.slot  = slot_reg;

    ssh_step u_step (
        .cfg (cfg),
        .st  (st),
        .cmd (in_cmd_reg),
        .din (in_byte_reg),
        .res (res)
    );

    // handshakes
    assign s_fire   = s_tvalid && s_tready;
    assign m_fire   = m_tvalid && m_tready;
    assign bat_done = m_fire && (bat_idx_reg == bat_lastidx_reg);
    assign load     = in_vld_reg && (!bat_vld_reg || bat_done);
    assign s_tready = !in_vld_reg || load;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_reg  <= '0;
            lens_reg <= '0;
        end else if (cfg_we) begin
            case (ssh_pkg::ssh_cfg_idx_t'(cfg_index))
                ssh_pkg::CFG_PATTERN_ZERO:  pat_reg[0] <= cfg_wdata;
                ssh_pkg::CFG_PATTERN_ONE:   pat_reg[1] <= cfg_wdata;
                ssh_pkg::CFG_PATTERN_TWO:   pat_reg[2] <= cfg_wdata;
                ssh_pkg::CFG_PATTERN_THREE: pat_reg[3] <= cfg_wdata;
                ssh_pkg::CFG_LENGTHS:       lens_reg <= cfg_wdata[ssh_pkg::LEN_W*NS-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_fire) begin
            in_vld_reg <= 1'b1;
        end else if (load) begin
            in_vld_reg <= 1'b0;
        end
        if (s_fire) begin
            in_cmd_reg  <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    // state update when a transaction moves into the batch register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hc_reg   <= '0;
            seen_reg <= 1'b0;
            slot_reg <= '0;
        end else if (load) begin
            hc_reg   <= res.next.hc;
            seen_reg <= res.next.seen;
            slot_reg <= res.next.slot;
        end
        if (load) begin
            held_reg <= res.next.held;
        end
    end

    // result batch, drained one result per cycle while m_tready is high
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bat_vld_reg <= 1'b0;
            bat_idx_reg <= '0;
        end else if (load) begin
            bat_vld_reg <= 1'b1;
            bat_idx_reg <= '0;
        end else if (bat_done) begin
            bat_vld_reg <= 1'b0;
        end else if (m_fire) begin
            bat_idx_reg <= bat_idx_reg + ssh_pkg::HC_W'(1);
        end
        if (load) begin
            bat_buf_reg     <= res.rel_bytes;
            bat_any_reg     <= (res.rel_cnt != '0);
            bat_lastidx_reg <= (res.rel_cnt == '0) ? '0 :
                               ssh_pkg::HC_W'(res.rel_cnt - ssh_pkg::CNT_W'(1));
            bat_stop_reg    <= res.next.seen;
            bat_slot_reg    <= res.next.slot;
        end
    end

    // output channel
    assign out_byte = bat_any_reg ? bat_buf_reg[bat_idx_reg] : 8'd0;
    assign m_tvalid = bat_vld_reg;
    assign m_tuser  = bat_any_reg;
    assign m_tlast  = (bat_idx_reg == bat_lastidx_reg);
    assign m_tdata  = {5'd0, bat_slot_reg, bat_stop_reg, out_byte};

endmodule

`default_nettype wire

FILE: hdl/ssh_checker.sv
`default_nettype none

module ssh_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [15:0]                    m_tdata,
    input wire logic                           m_tuser,
    input wire logic                           m_tlast
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result changed");

    // a status-only result is alone and carries a zero byte
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tlast && (m_tdata[7:0] == 8'd0))
        else $error("status result malformed");

    // a batch drains without gaps
    a_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("gap inside result batch");

    // match status is the same across one batch
    a_status_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tdata[10:8] == $past(m_tdata[10:8]))
        else $error("match status changed inside batch");

    // input is taken whenever the output side is empty
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

endmodule

bind stop_string_holdback_filter ssh_checker u_ssh_checker (.*);

`default_nettype wire
